FILE: rtl/core/cfpr_pkg.sv
package cfpr_pkg;

  localparam logic [7:0] CR_BYTE = 8'h0d;
  localparam logic [7:0] LF_BYTE = 8'h0a;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDLE_W  = 16;
  localparam int unsigned LEN_W   = 6;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd500;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_READ = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_STORED  = 2'd2,
    KIND_DROPPED = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

endpackage

FILE: rtl/core/crlf_frame_page_ring_unit.sv
// Received bytes and ticks are handled as they are accepted; a store or drop result sits in the
// output register from the next cycle, and the next request is taken only in a cycle where no read
// is streaming and the output register is empty or its result is accepted.
// A read of an N byte frame gives N payload outputs, one payload byte per cycle while the output
// is not stalled, paced by the single read port of the page store and stretched by any output stall.
// Reset clears the pointers, fill count, page lengths and idle count at once; the page store
// has no reset and needs no clearing pass, since only written entries are ever read.
module crlf_frame_page_ring_unit
  import cfpr_pkg::*;
#(
  parameter int unsigned PAGES      = 4,
  parameter int unsigned PAGE_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        rx_byte_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        out_byte_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic              overwrote_o,
  output logic              timed_out_o,
  output logic              last_o
);

  localparam int unsigned PW    = $clog2(PAGES);
  localparam int unsigned FW    = $clog2(PAGE_BYTES + 1);
  localparam int unsigned AW    = $clog2(PAGES * PAGE_BYTES);
  localparam int unsigned DEPTH = PAGES * PAGE_BYTES;
  localparam int unsigned EXT_W = FW + LEN_W;

  function automatic logic [LEN_W-1:0] to_out_len(logic [FW-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[LEN_W-1:0];
  endfunction

  function automatic logic [PW-1:0] next_page(logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(PAGES - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  timeout_q, timeout_d;
  logic [IDLE_W-1:0] idle_q, idle_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic              last_cr_q, last_cr_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     rp_q, rp_d;
  logic [PAGES-1:0]  full_q, full_d;
  logic [FW-1:0]     page_len_q [PAGES];
  logic [FW-1:0]     page_len_d [PAGES];

  logic [PW-1:0]     rd_page_q, rd_page_d;
  logic [FW-1:0]     len_q, len_d;
  logic [FW-1:0]     idx_q, idx_d;
  logic              tmo_q, tmo_d;

  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        out_byte_q;
  logic [LEN_W-1:0]  frame_length_q, frame_length_d;
  logic              overwrote_q, overwrote_d;
  logic              timed_out_q, timed_out_d;
  logic              last_q, last_d;

  logic [7:0]        page_store [DEPTH];
  logic              mem_we, mem_re, out_load;
  logic [AW-1:0]     wr_addr, rd_addr;

  logic              out_free, in_fire, tmo;
  logic [PW-1:0]     wp_nxt, rp_nxt;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign wp_nxt  = next_page(wp_q);
  assign rp_nxt  = next_page(rp_q);
  assign tmo     = (fill_q != '0) && (idle_q > timeout_q);
  assign wr_addr = AW'(wp_q) * AW'(PAGE_BYTES) + AW'(fill_q - FW'(2));
  assign rd_addr = AW'(rd_page_q) * AW'(PAGE_BYTES) + AW'(idx_q);

  always_comb begin
    state_d        = state_q;
    timeout_d      = timeout_q;
    idle_d         = idle_q;
    fill_d         = fill_q;
    last_cr_d      = last_cr_q;
    wp_d           = wp_q;
    rp_d           = rp_q;
    full_d         = full_q;
    page_len_d     = page_len_q;
    rd_page_d      = rd_page_q;
    len_d          = len_q;
    idx_d          = idx_q;
    tmo_d          = tmo_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    kind_d         = kind_q;
    frame_length_d = frame_length_q;
    overwrote_d    = overwrote_q;
    timed_out_d    = timed_out_q;
    last_d         = last_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    out_load       = 1'b0;

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_i)
            CMD_BYTE: begin
              if (fill_q == '0) begin
                if (rx_byte_i == CR_BYTE) begin
                  idle_d = '0;
                  fill_d = FW'(1);
                end
              end else if (fill_q == FW'(1)) begin
                if (rx_byte_i != LF_BYTE) begin
                  fill_d = '0;
                end else begin
                  idle_d = '0;
                  fill_d = FW'(2);
                end
              end else if (fill_q >= FW'(PAGE_BYTES)) begin
                // Frame fill has reached PAGE_BYTES: throw the partial frame away.
                fill_d         = '0;
                out_load       = 1'b1;
                kind_d         = KIND_DROPPED;
                frame_length_d = '0;
                overwrote_d    = 1'b0;
              end else begin
                mem_we    = 1'b1;
                idle_d    = '0;
                fill_d    = fill_q + FW'(1);
                last_cr_d = (rx_byte_i == CR_BYTE);
                if ((fill_q != FW'(2)) && (rx_byte_i == LF_BYTE) && last_cr_q) begin
                  out_load    = 1'b1;
                  overwrote_d = 1'b0;
                  if (fill_q == FW'(3)) begin
                    // Closing CR LF straight after the opening one: empty payload.
                    fill_d         = '0;
                    kind_d         = KIND_DROPPED;
                    frame_length_d = '0;
                  end else begin
                    page_len_d[wp_q] = fill_q - FW'(3);
                    full_d[wp_q]     = 1'b1;
                    wp_d             = wp_nxt;
                    fill_d           = '0;
                    kind_d           = KIND_STORED;
                    frame_length_d   = to_out_len(fill_q - FW'(3));
                    if (full_q[wp_nxt]) begin
                      full_d[wp_nxt]     = 1'b0;
                      page_len_d[wp_nxt] = '0;
                      overwrote_d        = 1'b1;
                    end
                  end
                end
              end
            end
            CMD_READ: begin
              // A stale partial frame on the write page (idle count past the timeout) is discarded by a read.
              if (tmo) begin
                fill_d = '0;
              end
              if (full_q[rp_q]) begin
                rp_d             = rp_nxt;
                full_d[rp_q]     = 1'b0;
                page_len_d[rp_q] = '0;
                len_d            = page_len_q[rp_q];
                rd_page_d        = rp_q;
                idx_d            = '0;
                tmo_d            = tmo;
                state_d          = ST_STREAM;
              end else begin
                out_load       = 1'b1;
                kind_d         = KIND_EMPTY;
                frame_length_d = '0;
                overwrote_d    = 1'b0;
                timed_out_d    = tmo;
                last_d         = 1'b1;
              end
            end
            CMD_TICK: begin
              if (idle_q != '1) begin
                idle_d = idle_q + IDLE_W'(1);
              end
            end
            default: begin
            end
          endcase
          if (out_load) begin
            out_valid_d = 1'b1;
            if (cmd_i != CMD_READ) begin
              timed_out_d = 1'b0;
              last_d      = 1'b1;
            end
          end
        end
      end
      ST_STREAM: begin
        if (out_free) begin
          mem_re         = 1'b1;
          out_valid_d    = 1'b1;
          kind_d         = KIND_DATA;
          frame_length_d = to_out_len(len_q);
          overwrote_d    = 1'b0;
          timed_out_d    = tmo_q;
          last_d         = ((idx_q + FW'(1)) == len_q);
          idx_d          = idx_q + FW'(1);
          if ((idx_q + FW'(1)) == len_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TIMEOUT_RESET;
      idle_q      <= '0;
      fill_q      <= '0;
      last_cr_q   <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PAGES; i++) begin
        page_len_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      timeout_q   <= timeout_d;
      idle_q      <= idle_d;
      fill_q      <= fill_d;
      last_cr_q   <= last_cr_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      page_len_q  <= page_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_page_q      <= rd_page_d;
    len_q          <= len_d;
    idx_q          <= idx_d;
    tmo_q          <= tmo_d;
    kind_q         <= kind_d;
    frame_length_q <= frame_length_d;
    overwrote_q    <= overwrote_d;
    timed_out_q    <= timed_out_d;
    last_q         <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_store[wr_addr] <= rx_byte_i;
    end
    if (mem_re) begin
      out_byte_q <= page_store[rd_addr];
    end else if (out_load) begin
      out_byte_q <= '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign out_byte_o     = out_byte_q;
  assign frame_length_o = frame_length_q;
  assign overwrote_o    = overwrote_q;
  assign timed_out_o    = timed_out_q;
  assign last_o         = last_q;

endmodule
